### design/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg: shared types and codes for the indexed list engine
// Request and response words, opcodes, status codes and the control word
// that the top level broadcasts along the row of storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ile_pkg;

	// Position width large enough for any supported depth and its count
	localparam int POS_W = 11;

	// Opcodes
	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_INSERT = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_WRITE  = 3'd4;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [2:0]  op;
		logic [5:0]  index;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic [1:0]  status;
		logic [6:0]  count;
	} rsp_t;

	// Broadcast control for every cell in the chain
	typedef struct packed {
		logic             load;
		logic             shift_up;
		logic             shift_down;
		logic [POS_W-1:0] load_pos;
		logic [POS_W-1:0] shift_pos;
		logic [POS_W-1:0] read_pos;
	} cell_ctl_t;

endpackage

`default_nettype wire

### design/ile_cell.sv
// ----------------------------------------------------------------------------
// ile_cell: one storage cell of the list chain
// Holds the word at a fixed list position. Loads the broadcast word, takes
// its lower neighbor's word on an insert shift, or its upper neighbor's word
// on a remove shift; offers its word on the read bus when selected.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_cell #(
	parameter int DATA_W = 32,
	parameter int POS    = 0
) (
	input  wire logic              clk,
	input  wire ile_pkg::cell_ctl_t ctl,
	input  wire logic [DATA_W-1:0] value,
	input  wire logic [DATA_W-1:0] prev_data,
	input  wire logic [DATA_W-1:0] next_data,
	output logic      [DATA_W-1:0] data,
	output logic      [DATA_W-1:0] rd_data
);
	import ile_pkg::*;

	localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

	logic [DATA_W-1:0] data_q;

	// Load, shift toward the back, or shift toward the front
	always_ff @(posedge clk) begin
		if (ctl.load && (ctl.load_pos == MY_POS)) begin
			data_q <= value;
		end else if (ctl.shift_up && (MY_POS > ctl.shift_pos)) begin
			data_q <= prev_data;
		end else if (ctl.shift_down && (MY_POS >= ctl.shift_pos)) begin
			data_q <= next_data;
		end
	end

	// Drive the read bus only when addressed
	assign data    = data_q;
	assign rd_data = (ctl.read_pos == MY_POS) ? data_q : '0;

endmodule

`default_nettype wire

### design/indexed_list_engine_top.sv
// Latency: a result word is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while responses are taken, insert and
// remove included; cells from the index up shift in parallel in that cycle.
// The response register frees as it is taken, so requests keep flowing.
// Reset clears the entry count and the response valid; cell contents are
// left undefined and are never read before written.
// ----------------------------------------------------------------------------
// indexed_list_engine_top: ordered list held in a shifting chain of cells
// Decodes each request against the entry count, broadcasts load and shift
// controls along the chain, and registers one response per request.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_engine_top #(
	parameter int DEPTH  = 64,
	parameter int DATA_W = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ile_pkg::req_t req,
	input  wire logic          req_valid,
	output logic               req_ready,
	output ile_pkg::rsp_t      rsp,
	output logic               rsp_valid,
	input  wire logic          rsp_ready
);
	import ile_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [POS_W-1:0] DEPTH_P = POS_W'(DEPTH);

	logic [CNT_W-1:0]  count_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              accept;
	logic [POS_W-1:0]  cnt_p;
	logic [POS_W-1:0]  idx_p;
	logic              in_range;
	logic              full;
	logic [63:0]       val_wide;
	logic [DATA_W-1:0] val_d;
	logic [DATA_W-1:0] rd_any;
	logic [63:0]       rd_wide;
	cell_ctl_t         ctl;
	logic [1:0]        status_d;
	logic              grow;
	logic              shrink;
	logic              give_data;
	logic [CNT_W-1:0]  count_d;
	logic [15:0]       count_wide;

	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DATA_W-1:0] cell_rd   [DEPTH];

	// Accept a new word whenever the response register is free or draining
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	assign cnt_p    = POS_W'(count_q);
	assign idx_p    = POS_W'(req.index);
	assign in_range = idx_p < cnt_p;
	assign full     = cnt_p == DEPTH_P;
	assign val_wide = 64'(req.value);
	assign val_d    = val_wide[DATA_W-1:0];

	// Decode the request against the current count
	always_comb begin
		status_d  = ST_OK;
		grow      = 1'b0;
		shrink    = 1'b0;
		give_data = 1'b0;
		ctl       = '0;
		ctl.load_pos  = idx_p;
		ctl.shift_pos = idx_p;
		ctl.read_pos  = idx_p;
		case (req.op)
			OP_APPEND: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					grow         = 1'b1;
					ctl.load     = 1'b1;
					ctl.load_pos = cnt_p;
				end
			end
			OP_INSERT: begin
				if (!in_range) begin
					status_d = ST_BAD_INDEX;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					grow         = 1'b1;
					ctl.load     = 1'b1;
					ctl.shift_up = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (!in_range) begin
					status_d = ST_BAD_INDEX;
				end else begin
					shrink         = 1'b1;
					give_data      = 1'b1;
					ctl.shift_down = 1'b1;
				end
			end
			OP_READ: begin
				if (!in_range) begin
					status_d = ST_BAD_INDEX;
				end else begin
					give_data = 1'b1;
				end
			end
			OP_WRITE: begin
				if (!in_range) begin
					status_d = ST_BAD_INDEX;
				end else begin
					ctl.load = 1'b1;
				end
			end
			default: begin
				status_d = ST_BAD_INDEX;
			end
		endcase
		// Hold the chain unless a word is taken this cycle
		if (!accept) begin
			ctl.load       = 1'b0;
			ctl.shift_up   = 1'b0;
			ctl.shift_down = 1'b0;
		end
	end

	// Row of cells wired to their neighbors; cell 0 sees val_d below it
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] prev_w;
		logic [DATA_W-1:0] next_w;
		if (i == 0) begin : g_first
			assign prev_w = val_d;
		end else begin : g_mid_lo
			assign prev_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_w = cell_data[i];
		end else begin : g_mid_hi
			assign next_w = cell_data[i+1];
		end
		ile_cell #(
			.DATA_W (DATA_W),
			.POS    (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.value     (val_d),
			.prev_data (prev_w),
			.next_data (next_w),
			.data      (cell_data[i]),
			.rd_data   (cell_rd[i])
		);
	end

	// Merge the read bus; at most one cell drives it
	always_comb begin
		rd_any = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_any = rd_any | cell_rd[i];
		end
	end
	assign rd_wide = 64'(rd_any);

	// Next entry count
	always_comb begin
		count_d = count_q;
		if (grow) begin
			count_d = count_q + CNT_W'(1);
		end else if (shrink) begin
			count_d = count_q - CNT_W'(1);
		end
	end
	assign count_wide = 16'(count_d);

	// Advance count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Capture the response word
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.result_value <= give_data ? rd_wide[31:0] : 32'd0;
			rsp_q.status       <= status_d;
			rsp_q.count        <= count_wide[6:0];
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for indexed_list_engine_top
// A queue in the bench tracks the list. Every accepted request updates it and
// leaves one expected response word, and each response word is checked against
// the oldest one. Directed tests cover the empty list, each operation, the
// range edges and the full list. Random traffic then grows and shrinks the
// list in phases while the request and response sides idle and stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import ile_pkg::*;

	localparam int LIST_DEPTH = 64;
	localparam int IDLE_LIMIT = 2000;

	// Opcodes left unused by the block
	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	logic  clk;
	logic  arst_n;
	req_t  req;
	logic  req_valid;
	logic  req_ready;
	rsp_t  rsp;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;

	logic [31:0] list_words[$];
	rsp_t        expected_rsp_q[$];
	int          mismatch_count = 0;
	int          burst_left = 0;
	int          stall_left = 0;
	int          stall_mode = 0;
	int          cycle_num = 0;
	int          idle_cycles = 0;

	indexed_list_engine_top #(
		.DEPTH  (LIST_DEPTH),
		.DATA_W (32)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one request to the list copy and return the response word it earns
	function automatic rsp_t list_apply(input req_t item);
		rsp_t r;
		int   idx;
		int   n;
		r = '0;
		r.status = ST_OK;
		idx = item.index;
		n = list_words.size();
		case (item.op)
			OP_APPEND: begin
				if (n >= LIST_DEPTH) r.status = ST_FULL;
				else list_words.push_back(item.value);
			end
			OP_INSERT: begin
				if (idx >= n) r.status = ST_BAD_INDEX;
				else if (n >= LIST_DEPTH) r.status = ST_FULL;
				else list_words.insert(idx, item.value);
			end
			OP_REMOVE: begin
				if (idx >= n) begin
					r.status = ST_BAD_INDEX;
				end else begin
					r.result_value = list_words[idx];
					list_words.delete(idx);
				end
			end
			OP_READ: begin
				if (idx >= n) r.status = ST_BAD_INDEX;
				else r.result_value = list_words[idx];
			end
			OP_WRITE: begin
				if (idx >= n) r.status = ST_BAD_INDEX;
				else list_words[idx] = item.value;
			end
			default: r.status = ST_BAD_INDEX;
		endcase
		r.count = 7'(list_words.size());
		return r;
	endfunction

	function automatic req_t make_req(input logic [2:0] op, input int idx,
			input logic [31:0] value);
		req_t item;
		item.op = op;
		item.index = 6'(idx);
		item.value = value;
		return item;
	endfunction

	// Send one request word; bursts of back-to-back words with idle gaps between
	task automatic issue_request(input req_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		expected_rsp_q.push_back(list_apply(item));
	endtask

	task automatic test_empty_list();
		issue_request(make_req(OP_READ, 0, 32'h0));
		issue_request(make_req(OP_REMOVE, 0, 32'h0));
		issue_request(make_req(OP_WRITE, 0, 32'h1234_5678));
		issue_request(make_req(OP_INSERT, 0, 32'hDEAD_BEEF));
		issue_request(make_req(OP_INSERT, 63, 32'hFFFF_FFFF));
		issue_request(make_req(OP_SPARE_5, 0, 32'hFFFF_FFFF));
		issue_request(make_req(OP_SPARE_6, 63, 32'h0));
		issue_request(make_req(OP_SPARE_7, 21, 32'hA5A5_A5A5));
	endtask

	task automatic test_basic_ops();
		issue_request(make_req(OP_APPEND, 63, 32'hFFFF_FFFF));
		issue_request(make_req(OP_APPEND, 0, 32'h0000_0000));
		issue_request(make_req(OP_APPEND, 0, 32'h5A5A_5A5A));
		issue_request(make_req(OP_INSERT, 0, 32'h1111_1111));
		issue_request(make_req(OP_INSERT, 2, 32'h2222_2222));
		issue_request(make_req(OP_INSERT, 4, 32'h3333_3333));
		issue_request(make_req(OP_READ, 0, 32'h0));
		issue_request(make_req(OP_READ, 5, 32'h0));
		issue_request(make_req(OP_READ, 6, 32'h0));
		issue_request(make_req(OP_WRITE, 1, 32'hCAFE_F00D));
		issue_request(make_req(OP_WRITE, 63, 32'hBAD0_BAD0));
		issue_request(make_req(OP_REMOVE, 0, 32'h0));
		issue_request(make_req(OP_REMOVE, 4, 32'h0));
		issue_request(make_req(OP_REMOVE, 1, 32'h0));
		issue_request(make_req(OP_REMOVE, 3, 32'h0));
		issue_request(make_req(OP_READ, 1, 32'h0));
	endtask

	task automatic test_full_list();
		while (list_words.size() < LIST_DEPTH)
			issue_request(make_req(OP_APPEND, 0, $urandom));
		issue_request(make_req(OP_APPEND, 0, 32'hFFFF_FFFF));
		issue_request(make_req(OP_INSERT, 0, 32'h0));
		issue_request(make_req(OP_INSERT, 63, 32'hFFFF_FFFF));
		issue_request(make_req(OP_READ, 63, 32'h0));
		issue_request(make_req(OP_WRITE, 63, 32'hFFFF_FFFF));
		issue_request(make_req(OP_REMOVE, 63, 32'h0));
		issue_request(make_req(OP_READ, 63, 32'h0));
		issue_request(make_req(OP_INSERT, 62, 32'h0));
		issue_request(make_req(OP_REMOVE, 0, 32'h0));
	endtask

	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 32'h0;
		if (r == 1) return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	// Weighted opcode: grow_pct sets the share of appends and inserts
	function automatic logic [2:0] pick_op(input int grow_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			case ($urandom_range(0, 2))
				0: return OP_SPARE_5;
				1: return OP_SPARE_6;
				default: return OP_SPARE_7;
			endcase
		end
		if (r < 3 + grow_pct) return ($urandom_range(0, 1) != 0) ? OP_APPEND : OP_INSERT;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return OP_REMOVE;
			4, 5, 6: return OP_READ;
			default: return OP_WRITE;
		endcase
	endfunction

	function automatic int pick_index();
		int n;
		n = list_words.size();
		if (n > 0 && $urandom_range(0, 99) < 85) return $urandom_range(0, n - 1);
		if (n < LIST_DEPTH && $urandom_range(0, 1) != 0) return $urandom_range(n, 63);
		return $urandom_range(0, 63);
	endfunction

	// Alternate growing, shrinking and mixed phases so the list sweeps its range
	task automatic test_random_traffic();
		int sent;
		int phase_len;
		int grow_pct;
		sent = 0;
		while (sent < 650) begin
			case ($urandom_range(0, 2))
				0: grow_pct = 60;
				1: grow_pct = 12;
				default: grow_pct = 32;
			endcase
			phase_len = $urandom_range(40, 150);
			repeat (phase_len) begin
				if (sent < 650) begin
					issue_request(make_req(pick_op(grow_pct), pick_index(), pick_word()));
					sent++;
				end
			end
		end
	endtask

	// Response side stalls on its own pattern, changing mode now and then
	always @(posedge clk) begin
		cycle_num <= cycle_num + 1;
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= ($urandom_range(0, 1) != 0);
			2: rsp_ready <= ($urandom_range(0, 3) == 0);
			default: rsp_ready <= ((cycle_num % 5) < 2);
		endcase
	end

	function automatic void log_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
	endfunction

	// Check each taken response word against the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp_q.size() == 0) begin
				log_mismatch("unexpected response word", 32'h0, rsp.result_value);
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp.result_value !== want.result_value)
					log_mismatch("result_value", want.result_value, rsp.result_value);
				if (rsp.status !== want.status)
					log_mismatch("status", 32'(want.status), 32'(rsp.status));
				if (rsp.count !== want.count)
					log_mismatch("count", 32'(want.count), 32'(rsp.count));
			end
		end
	end

	// Abort if neither side moves a word for too long
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_basic_ops();
		test_full_list();
		test_random_traffic();
		req_valid <= 1'b0;
		while (expected_rsp_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire
